FILE: rtl/token_lexer_stream_top_assert.svh
// Assertion macros shared by the lexer checker.
`ifndef TOKEN_LEXER_STREAM_TOP_ASSERT_SVH
`define TOKEN_LEXER_STREAM_TOP_ASSERT_SVH

// Plain clocked property, disabled while reset is asserted.
`define TLS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication whose consequent holds in the next cycle.
`define TLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tls_pkg.sv
// Shared types, constants and keyword table of the token lexer.
`timescale 1ns / 1ps
`default_nettype none
package tls_pkg;

  localparam int unsigned OffsetBitsDef = 16;
  localparam int unsigned KeywordBytesDef = 8;
  localparam int unsigned QueueDepth = 4;

  // Token kinds
  localparam logic [5:0] K_IDENT   = 6'd0;
  localparam logic [5:0] K_INT     = 6'd9;
  localparam logic [5:0] K_STRING  = 6'd10;
  localparam logic [5:0] K_COMMENT = 6'd11;
  localparam logic [5:0] K_LPAREN  = 6'd12;
  localparam logic [5:0] K_RPAREN  = 6'd13;
  localparam logic [5:0] K_LBRACK  = 6'd14;
  localparam logic [5:0] K_RBRACK  = 6'd15;
  localparam logic [5:0] K_LBRACE  = 6'd16;
  localparam logic [5:0] K_RBRACE  = 6'd17;
  localparam logic [5:0] K_COMMA   = 6'd18;
  localparam logic [5:0] K_AMP     = 6'd19;
  localparam logic [5:0] K_AMPAMP  = 6'd20;
  localparam logic [5:0] K_BAR     = 6'd21;
  localparam logic [5:0] K_BARBAR  = 6'd22;
  localparam logic [5:0] K_PLUS    = 6'd23;
  localparam logic [5:0] K_INC     = 6'd24;
  localparam logic [5:0] K_PLUSEQ  = 6'd25;
  localparam logic [5:0] K_MINUS   = 6'd26;
  localparam logic [5:0] K_DEC     = 6'd27;
  localparam logic [5:0] K_MINUSEQ = 6'd28;
  localparam logic [5:0] K_ASSIGN  = 6'd29;
  localparam logic [5:0] K_EQEQ    = 6'd30;
  localparam logic [5:0] K_CHAR    = 6'd31;
  localparam logic [5:0] K_END     = 6'd32;
  localparam logic [5:0] K_ERROR   = 6'd33;

  // Characters
  localparam logic [7:0] C_NUL    = 8'h00;
  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_NL     = 8'h0A;
  localparam logic [7:0] C_SPACE  = 8'h20;
  localparam logic [7:0] C_QUOTE  = 8'h22;
  localparam logic [7:0] C_HASH   = 8'h23;
  localparam logic [7:0] C_DOLLAR = 8'h24;
  localparam logic [7:0] C_AMP    = 8'h26;
  localparam logic [7:0] C_LPAREN = 8'h28;
  localparam logic [7:0] C_RPAREN = 8'h29;
  localparam logic [7:0] C_PLUS   = 8'h2B;
  localparam logic [7:0] C_COMMA  = 8'h2C;
  localparam logic [7:0] C_MINUS  = 8'h2D;
  localparam logic [7:0] C_ZERO   = 8'h30;
  localparam logic [7:0] C_EQ     = 8'h3D;
  localparam logic [7:0] C_LBRACK = 8'h5B;
  localparam logic [7:0] C_BSLASH = 8'h5C;
  localparam logic [7:0] C_RBRACK = 8'h5D;
  localparam logic [7:0] C_UNDER  = 8'h5F;
  localparam logic [7:0] C_N      = 8'h6E;
  localparam logic [7:0] C_LBRACE = 8'h7B;
  localparam logic [7:0] C_BAR    = 8'h7C;
  localparam logic [7:0] C_RBRACE = 8'h7D;

  // Lexer modes, one-hot
  typedef enum logic [11:0] {
    M_IDLE    = 12'b0000_0000_0001,
    M_IDENT   = 12'b0000_0000_0010,
    M_NUM     = 12'b0000_0000_0100,
    M_STR     = 12'b0000_0000_1000,
    M_ESC     = 12'b0000_0001_0000,
    M_COMMENT = 12'b0000_0010_0000,
    M_AMP     = 12'b0000_0100_0000,
    M_BAR     = 12'b0000_1000_0000,
    M_PLUS    = 12'b0001_0000_0000,
    M_MINUS   = 12'b0010_0000_0000,
    M_EQ      = 12'b0100_0000_0000,
    M_SKIP    = 12'b1000_0000_0000
  } mode_e;

  // One result record
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [31:0] value;
    logic [7:0]  ch;
    logic        last;
  } rec_t;

  // Results of one byte, handed from lexer to queue
  typedef struct packed {
    logic v0;
    logic v1;
    rec_t r0;
    rec_t r1;
  } lex_out_t;

  // Keyword spellings, byte i in bits 8i+7..8i
  function automatic logic [63:0] kw_word(input logic [2:0] k);
    logic [63:0] w;
    case (k)
      3'd0:    w = 64'h6669;
      3'd1:    w = 64'h65736c65;
      3'd2:    w = 64'h726f66;
      3'd3:    w = 64'h656c696877;
      3'd4:    w = 64'h6e7275746572;
      3'd5:    w = 64'h6b61657262;
      3'd6:    w = 64'h65756e69746e6f63;
      default: w = 64'h6e6f6974636e7566;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      3'd0:    n = 4'd2;
      3'd1:    n = 4'd4;
      3'd2:    n = 4'd3;
      3'd3:    n = 4'd5;
      3'd4:    n = 4'd6;
      3'd5:    n = 4'd5;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           b == C_UNDER || b == C_DOLLAR;
  endfunction

  function automatic logic is_decimal(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/token_lexer_stream_top.sv
// Top level of the streaming token lexer.
//
// Input channel: one source byte per transaction on text_byte_i, taken when
// push is high and full is low. Byte 0 ends the text and resets offsets.
// Result channel: queue style; while empty is low the oldest token record is
// on the result ports, and pop takes it.
// Each byte is classified in the cycle it is taken; its results (zero, one
// or two) enter a four-entry result queue at that edge and can be popped
// from the next cycle.
// One byte is taken every cycle as long as the queue has two free entries;
// the single read port of the queue gives at most one result per cycle, so a
// byte stream that yields two results per byte is held back by full.
// Reset empties the queue and returns the lexer to the between-tokens state
// at offset zero. When the receiver stalls, the queue fills and full rises;
// no transaction is lost.
`timescale 1ns / 1ps
`default_nettype none
module token_lexer_stream_top #(
  parameter int unsigned OFFSET_BITS = tls_pkg::OffsetBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  text_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [5:0]       token_kind_o,
  output logic [15:0]      token_start_o,
  output logic [15:0]      token_length_o,
  output logic [31:0]      integer_value_o,
  output logic [7:0]       string_char_o,
  output logic             last_of_run_o
);

  tls_pkg::lex_out_t lex_out;
  tls_pkg::rec_t     head;
  logic              room, accept;

  assign full   = !room;
  assign accept = push && room;

  tls_lexer #(.OFFSET_BITS(OFFSET_BITS)) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .byte_i (text_byte_i),
    .out_o  (lex_out)
  );

  tls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (accept),
    .wr_i    (lex_out),
    .pop_i   (pop),
    .room_o  (room),
    .empty_o (empty),
    .head_o  (head)
  );

  assign token_kind_o    = head.kind;
  assign token_start_o   = head.start;
  assign token_length_o  = head.length;
  assign integer_value_o = head.value;
  assign string_char_o   = head.ch;
  assign last_of_run_o   = head.last;

endmodule
`default_nettype wire

FILE: rtl/tls_lexer.sv
// Front end: classifies each byte and forms up to two result records.
`timescale 1ns / 1ps
`default_nettype none
module tls_lexer #(
  parameter int unsigned OFFSET_BITS = tls_pkg::OffsetBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic [7:0]      byte_i,
  output tls_pkg::lex_out_t    out_o
);

  tls_pkg::mode_e mode_q, mode_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [63:0] win_q, win_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;

  function automatic logic [15:0] lo16(input logic [OFFSET_BITS-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[15:0];
  endfunction

  function automatic tls_pkg::rec_t mk(input logic [5:0] k, input logic [15:0] s,
                                       input logic [15:0] l, input logic [31:0] v,
                                       input logic [7:0] c);
    tls_pkg::rec_t r;
    r.kind = k; r.start = s; r.length = l; r.value = v; r.ch = c; r.last = 1'b0;
    return r;
  endfunction

  // Keyword lookup on the held identifier
  logic [5:0] id_kind;
  always_comb begin
    id_kind = tls_pkg::K_IDENT;
    for (int k = 7; k >= 0; k--) begin
      if (cnt_q == tls_pkg::kw_len(3'(k)) && win_q == tls_pkg::kw_word(3'(k))) begin
        id_kind = 6'(k + 1);
      end
    end
  end

  // Saturating decimal accumulate
  logic [35:0] acc_x10;
  logic [31:0] acc_next;
  always_comb begin
    acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
              36'(byte_i - tls_pkg::C_ZERO);
    acc_next = (acc_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_x10[31:0];
  end

  // Token start on the current byte
  logic           st_v;
  tls_pkg::rec_t  st_r;
  tls_pkg::mode_e st_mode;
  logic [15:0]    off16;
  always_comb begin
    off16   = lo16(off_q);
    st_v    = 1'b0;
    st_r    = mk(tls_pkg::K_END, off16, 16'd0, 32'd0, 8'd0);
    st_mode = tls_pkg::M_IDLE;
    if (tls_pkg::is_alpha(byte_i)) begin
      st_mode = tls_pkg::M_IDENT;
    end else if (tls_pkg::is_decimal(byte_i)) begin
      st_mode = tls_pkg::M_NUM;
    end else begin
      case (byte_i)
        tls_pkg::C_SPACE, tls_pkg::C_TAB, tls_pkg::C_NL: st_mode = tls_pkg::M_IDLE;
        tls_pkg::C_NUL:    st_v = 1'b1;
        tls_pkg::C_QUOTE:  st_mode = tls_pkg::M_STR;
        tls_pkg::C_HASH:   st_mode = tls_pkg::M_COMMENT;
        tls_pkg::C_AMP:    st_mode = tls_pkg::M_AMP;
        tls_pkg::C_BAR:    st_mode = tls_pkg::M_BAR;
        tls_pkg::C_PLUS:   st_mode = tls_pkg::M_PLUS;
        tls_pkg::C_MINUS:  st_mode = tls_pkg::M_MINUS;
        tls_pkg::C_EQ:     st_mode = tls_pkg::M_EQ;
        tls_pkg::C_LPAREN: begin st_v = 1'b1; st_r.kind = tls_pkg::K_LPAREN; end
        tls_pkg::C_RPAREN: begin st_v = 1'b1; st_r.kind = tls_pkg::K_RPAREN; end
        tls_pkg::C_LBRACK: begin st_v = 1'b1; st_r.kind = tls_pkg::K_LBRACK; end
        tls_pkg::C_RBRACK: begin st_v = 1'b1; st_r.kind = tls_pkg::K_RBRACK; end
        tls_pkg::C_LBRACE: begin st_v = 1'b1; st_r.kind = tls_pkg::K_LBRACE; end
        tls_pkg::C_RBRACE: begin st_v = 1'b1; st_r.kind = tls_pkg::K_RBRACE; end
        tls_pkg::C_COMMA:  begin st_v = 1'b1; st_r.kind = tls_pkg::K_COMMA; end
        default: begin
          st_v = 1'b1; st_r.kind = tls_pkg::K_ERROR; st_mode = tls_pkg::M_SKIP;
        end
      endcase
      if (st_v && byte_i != tls_pkg::C_NUL) st_r.length = 16'd1;
    end
  end

  // Main decode: pending token flush, then start or end-of-text
  logic           fl_v, do_start, end_v;
  tls_pkg::rec_t  fl_r, sec_r;
  logic [OFFSET_BITS-1:0] off_p1, off_m1;
  logic           is_an;
  logic [7:0]     esc_ch;
  logic           esc_ok;
  always_comb begin
    off_p1   = off_q + OFFSET_BITS'(1);
    off_m1   = off_q - OFFSET_BITS'(1);
    is_an    = tls_pkg::is_alpha(byte_i) || tls_pkg::is_decimal(byte_i);
    fl_v     = 1'b0;
    fl_r     = mk(tls_pkg::K_IDENT, lo16(start_q), lo16(off_q - start_q), 32'd0, 8'd0);
    do_start = 1'b0;
    end_v    = 1'b0;
    mode_d   = mode_q;
    win_d    = win_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    esc_ok   = 1'b1;
    esc_ch   = byte_i;
    case (byte_i)
      tls_pkg::C_BSLASH, tls_pkg::C_QUOTE: esc_ch = byte_i;
      tls_pkg::C_N:    esc_ch = tls_pkg::C_NL;
      tls_pkg::C_ZERO: esc_ch = tls_pkg::C_NUL;
      default:         esc_ok = 1'b0;
    endcase
    unique case (mode_q)
      tls_pkg::M_IDENT: begin
        if (is_an) begin
          for (int i = 0; i < int'(tls_pkg::KeywordBytesDef); i++) begin
            if (cnt_q == 4'(i)) win_d[8*i +: 8] = win_q[8*i +: 8] | byte_i;
          end
          if (cnt_q < 4'(tls_pkg::KeywordBytesDef + 1)) cnt_d = cnt_q + 4'd1;
        end else begin
          fl_v = 1'b1; fl_r.kind = id_kind; do_start = 1'b1;
        end
      end
      tls_pkg::M_NUM: begin
        if (tls_pkg::is_decimal(byte_i)) begin
          acc_d = acc_next;
        end else begin
          fl_v = 1'b1; fl_r.kind = tls_pkg::K_INT; fl_r.value = acc_q; do_start = 1'b1;
        end
      end
      tls_pkg::M_STR: begin
        fl_r.kind = tls_pkg::K_STRING;
        if (byte_i == tls_pkg::C_NUL) begin
          fl_v = 1'b1; end_v = 1'b1; mode_d = tls_pkg::M_IDLE;
        end else if (byte_i == tls_pkg::C_QUOTE) begin
          fl_v = 1'b1; fl_r.length = lo16(off_p1 - start_q); mode_d = tls_pkg::M_IDLE;
        end else if (byte_i == tls_pkg::C_BSLASH) begin
          mode_d = tls_pkg::M_ESC;
        end else begin
          fl_v = 1'b1;
          fl_r = mk(tls_pkg::K_CHAR, lo16(off_q), 16'd1, 32'd0, byte_i);
        end
      end
      tls_pkg::M_ESC: begin
        if (byte_i == tls_pkg::C_NUL) begin
          fl_v = 1'b1; fl_r.kind = tls_pkg::K_STRING; end_v = 1'b1;
          mode_d = tls_pkg::M_IDLE;
        end else begin
          mode_d = tls_pkg::M_STR;
          fl_v   = esc_ok;
          fl_r   = mk(tls_pkg::K_CHAR, lo16(off_m1), 16'd2, 32'd0, esc_ch);
        end
      end
      tls_pkg::M_COMMENT: begin
        fl_r.kind = tls_pkg::K_COMMENT;
        if (byte_i == tls_pkg::C_NL) begin
          fl_v = 1'b1; mode_d = tls_pkg::M_IDLE;
        end else if (byte_i == tls_pkg::C_NUL) begin
          fl_v = 1'b1; end_v = 1'b1; mode_d = tls_pkg::M_IDLE;
        end
      end
      tls_pkg::M_AMP, tls_pkg::M_BAR, tls_pkg::M_PLUS, tls_pkg::M_MINUS,
      tls_pkg::M_EQ: begin
        fl_v = 1'b1;
        fl_r.length = 16'd2;
        mode_d = tls_pkg::M_IDLE;
        if (mode_q == tls_pkg::M_AMP && byte_i == tls_pkg::C_AMP) begin
          fl_r.kind = tls_pkg::K_AMPAMP;
        end else if (mode_q == tls_pkg::M_BAR && byte_i == tls_pkg::C_BAR) begin
          fl_r.kind = tls_pkg::K_BARBAR;
        end else if (mode_q == tls_pkg::M_PLUS && byte_i == tls_pkg::C_PLUS) begin
          fl_r.kind = tls_pkg::K_INC;
        end else if (mode_q == tls_pkg::M_PLUS && byte_i == tls_pkg::C_EQ) begin
          fl_r.kind = tls_pkg::K_PLUSEQ;
        end else if (mode_q == tls_pkg::M_MINUS && byte_i == tls_pkg::C_MINUS) begin
          fl_r.kind = tls_pkg::K_DEC;
        end else if (mode_q == tls_pkg::M_MINUS && byte_i == tls_pkg::C_EQ) begin
          fl_r.kind = tls_pkg::K_MINUSEQ;
        end else if (mode_q == tls_pkg::M_EQ && byte_i == tls_pkg::C_EQ) begin
          fl_r.kind = tls_pkg::K_EQEQ;
        end else begin
          // Single-byte operator; this byte starts the next token
          fl_r.length = 16'd1;
          do_start = 1'b1;
          case (mode_q)
            tls_pkg::M_AMP:   fl_r.kind = tls_pkg::K_AMP;
            tls_pkg::M_BAR:   fl_r.kind = tls_pkg::K_BAR;
            tls_pkg::M_PLUS:  fl_r.kind = tls_pkg::K_PLUS;
            tls_pkg::M_MINUS: fl_r.kind = tls_pkg::K_MINUS;
            default:          fl_r.kind = tls_pkg::K_ASSIGN;
          endcase
        end
      end
      tls_pkg::M_SKIP: begin
        if (byte_i == tls_pkg::C_NUL) begin
          end_v = 1'b1; mode_d = tls_pkg::M_IDLE;
        end
      end
      default: do_start = 1'b1;
    endcase
    start_d = start_q;
    if (do_start) begin
      mode_d  = st_mode;
      start_d = off_q;
      win_d   = 64'(byte_i);
      cnt_d   = 4'd1;
      acc_d   = 32'(byte_i - tls_pkg::C_ZERO);
    end
    off_d = (byte_i == tls_pkg::C_NUL) ? '0 : off_p1;
    sec_r = do_start ? st_r : mk(tls_pkg::K_END, off16, 16'd0, 32'd0, 8'd0);
  end

  // Pack results in order and mark the last one
  logic sec_v;
  always_comb begin
    sec_v     = (do_start && st_v) || end_v;
    out_o.v0  = fl_v || sec_v;
    out_o.v1  = fl_v && sec_v;
    out_o.r0  = fl_v ? fl_r : sec_r;
    out_o.r1  = sec_r;
    out_o.r0.last = !(fl_v && sec_v);
    out_o.r1.last = 1'b1;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tls_pkg::M_IDLE;
      start_q <= '0;
      off_q   <= '0;
      win_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (en_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      off_q   <= off_d;
      win_q   <= win_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tls_queue.sv
// Back end: result queue taking up to two records a cycle, giving one.
`timescale 1ns / 1ps
`default_nettype none
module tls_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire tls_pkg::lex_out_t wr_i,
  input  wire logic              pop_i,
  output logic                   room_o,
  output logic                   empty_o,
  output tls_pkg::rec_t          head_o
);

  localparam int unsigned PtrBits = $clog2(tls_pkg::QueueDepth);

  tls_pkg::rec_t mem_q [tls_pkg::QueueDepth];
  logic [PtrBits-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PtrBits:0]   cnt_q, cnt_d;
  logic               do_pop;
  logic [1:0]         n_wr;

  assign empty_o = (cnt_q == '0);
  assign room_o  = (cnt_q <= (PtrBits+1)'(tls_pkg::QueueDepth - 2));
  assign head_o  = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill bookkeeping
  always_comb begin
    n_wr  = wr_en_i ? ({1'b0, wr_i.v0} + {1'b0, wr_i.v1}) : 2'd0;
    wp_d  = wp_q + PtrBits'(n_wr);
    rp_d  = rp_q + PtrBits'(do_pop);
    cnt_d = cnt_q + (PtrBits+1)'(n_wr) - (PtrBits+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Record storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_i.v0) mem_q[wp_q] <= wr_i.r0;
    if (wr_en_i && wr_i.v1) mem_q[wp_q + PtrBits'(1)] <= wr_i.r1;
  end

endmodule
`default_nettype wire

FILE: rtl/tls_checker.sv
// Port-level checker for the token lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "token_lexer_stream_top_assert.svh"
module tls_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [5:0]  token_kind_o,
  input wire logic [15:0] token_length_o,
  input wire logic [31:0] integer_value_o,
  input wire logic [7:0]  string_char_o
);

  `TLS_ASSERT_NEXT(a_head_holds, clk_i, rst_ni, !empty && !pop, !empty && $stable(token_kind_o), "head changed while stalled")
  `TLS_ASSERT(a_end_len, clk_i, rst_ni, !empty && token_kind_o == tls_pkg::K_END |-> token_length_o == 16'd0, "end token with length")
  `TLS_ASSERT(a_value_int, clk_i, rst_ni, !empty && token_kind_o != tls_pkg::K_INT |-> integer_value_o == 32'd0, "value on non-integer")
  `TLS_ASSERT(a_char_only, clk_i, rst_ni, !empty && token_kind_o != tls_pkg::K_CHAR |-> string_char_o == 8'd0, "char on non-char")

endmodule

bind token_lexer_stream_top tls_checker u_tls_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .token_kind_o    (token_kind_o),
  .token_length_o  (token_length_o),
  .integer_value_o (integer_value_o),
  .string_char_o   (string_char_o)
);
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the streaming token lexer: a byte driver with a
// built-in token predictor, and a result monitor that checks each record.
`timescale 1ns / 1ps
module tb;
  import tls_pkg::*;

  // Stream markers in the byte queue (non-negative entries are text bytes)
  localparam int DRAIN   = -1;
  localparam int HOLD    = -2;
  localparam int PHASE_A = -3;
  localparam int PHASE_B = -4;
  localparam int PHASE_C = -5;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [31:0] value;
    logic [7:0]  ch;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  text_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [5:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [31:0] integer_value;
  logic [7:0]  string_char;
  logic        last_of_run;

  token_lexer_stream_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .text_byte_i     (text_byte),
    .empty           (empty),
    .pop             (pop),
    .token_kind_o    (token_kind),
    .token_start_o   (token_start),
    .token_length_o  (token_length),
    .integer_value_o (integer_value),
    .string_char_o   (string_char),
    .last_of_run_o   (last_of_run)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int     text_q[$];
  token_t token_q[$];
  token_t step_q[$];
  int     errors = 0;
  int     snd_idle = 0;
  int     rcv_idle = 0;
  int     hold_req = 0;

  // Lexer shadow state
  mode_e       lx_mode = M_IDLE;
  logic [15:0] tok_start = '0;
  logic [15:0] cur_off = '0;
  logic [63:0] kw_win = '0;
  logic [31:0] num_acc = '0;
  int          id_cnt = 0;

  string kw_names[8] = '{"if", "else", "for", "while", "return", "break",
                         "continue", "function"};

  task automatic report(string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic bit ident_byte(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == C_UNDER ||
           b == C_DOLLAR;
  endfunction

  function automatic bit digit_byte(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic add_token(logic [5:0] k, logic [15:0] s, logic [15:0] len,
                           logic [31:0] v, logic [7:0] c);
    token_t t;
    t = '{k, s, len, v, c, 1'b0};
    step_q.push_back(t);
  endtask

  function automatic logic [5:0] ident_kind();
    logic [5:0] k;
    bit         hit;
    k = K_IDENT;
    for (int i = 0; i < 8; i++) begin
      hit = (id_cnt == kw_names[i].len());
      for (int j = 0; j < kw_names[i].len(); j++)
        if (kw_win[8*j +: 8] != kw_names[i][j]) hit = 0;
      if (hit) k = 6'(i + 1);
    end
    return k;
  endfunction

  task automatic end_of_text(logic [15:0] off);
    add_token(K_END, off, 16'd0, 32'd0, 8'd0);
    lx_mode = M_IDLE;
  endtask

  // Byte arriving between tokens
  task automatic begin_token(logic [7:0] b, logic [15:0] off);
    logic [5:0] k;
    lx_mode = M_IDLE;
    tok_start = off;
    k = K_ERROR;
    if (ident_byte(b)) begin
      kw_win = {56'd0, b};
      id_cnt = 1;
      lx_mode = M_IDENT;
      return;
    end
    if (digit_byte(b)) begin
      num_acc = 32'(b - C_ZERO);
      lx_mode = M_NUM;
      return;
    end
    case (b)
      C_SPACE, C_TAB, C_NL: return;
      C_NUL: begin
        end_of_text(off);
        return;
      end
      C_QUOTE:  lx_mode = M_STR;
      C_HASH:   lx_mode = M_COMMENT;
      C_AMP:    lx_mode = M_AMP;
      C_BAR:    lx_mode = M_BAR;
      C_PLUS:   lx_mode = M_PLUS;
      C_MINUS:  lx_mode = M_MINUS;
      C_EQ:     lx_mode = M_EQ;
      C_LPAREN: k = K_LPAREN;
      C_RPAREN: k = K_RPAREN;
      C_LBRACK: k = K_LBRACK;
      C_RBRACK: k = K_RBRACK;
      C_LBRACE: k = K_LBRACE;
      C_RBRACE: k = K_RBRACE;
      C_COMMA:  k = K_COMMA;
      default: begin
        add_token(K_ERROR, off, 16'd1, 32'd0, 8'd0);
        lx_mode = M_SKIP;
        return;
      end
    endcase
    if (lx_mode == M_IDLE) add_token(k, off, 16'd1, 32'd0, 8'd0);
  endtask

  // Operator with one byte of lookahead
  task automatic finish_op(logic [7:0] b, logic [15:0] off, logic [7:0] c1,
                           logic [5:0] k1, logic [7:0] c2, logic [5:0] k2,
                           logic [5:0] k_one);
    if (b == c1) begin
      add_token(k1, tok_start, 16'd2, 32'd0, 8'd0);
      lx_mode = M_IDLE;
    end else if (c2 != 8'd0 && b == c2) begin
      add_token(k2, tok_start, 16'd2, 32'd0, 8'd0);
      lx_mode = M_IDLE;
    end else begin
      add_token(k_one, tok_start, 16'd1, 32'd0, 8'd0);
      begin_token(b, off);
    end
  endtask

  // Predict the records of one accepted byte and queue them
  task automatic lex_byte(logic [7:0] b);
    logic [15:0] off;
    logic [35:0] prod;
    logic [7:0]  c;
    off = cur_off;
    step_q.delete();
    case (lx_mode)
      M_IDENT: begin
        if (ident_byte(b) || digit_byte(b)) begin
          if (id_cnt < 8) kw_win[8*id_cnt +: 8] = b;
          if (id_cnt < 9) id_cnt++;
        end else begin
          add_token(ident_kind(), tok_start, off - tok_start, 32'd0, 8'd0);
          begin_token(b, off);
        end
      end
      M_NUM: begin
        if (digit_byte(b)) begin
          prod = 36'(num_acc) * 36'd10 + 36'(b - C_ZERO);
          num_acc = (prod > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
        end else begin
          add_token(K_INT, tok_start, off - tok_start, num_acc, 8'd0);
          begin_token(b, off);
        end
      end
      M_STR: begin
        if (b == C_NUL) begin
          add_token(K_STRING, tok_start, off - tok_start, 32'd0, 8'd0);
          end_of_text(off);
        end else if (b == C_QUOTE) begin
          add_token(K_STRING, tok_start, off + 16'd1 - tok_start, 32'd0, 8'd0);
          lx_mode = M_IDLE;
        end else if (b == C_BSLASH) begin
          lx_mode = M_ESC;
        end else begin
          add_token(K_CHAR, off, 16'd1, 32'd0, b);
        end
      end
      M_ESC: begin
        if (b == C_NUL) begin
          add_token(K_STRING, tok_start, off - tok_start, 32'd0, 8'd0);
          end_of_text(off);
        end else begin
          lx_mode = M_STR;
          if (b == C_BSLASH || b == C_QUOTE || b == C_N || b == C_ZERO) begin
            c = (b == C_N) ? C_NL : (b == C_ZERO) ? C_NUL : b;
            add_token(K_CHAR, off - 16'd1, 16'd2, 32'd0, c);
          end
        end
      end
      M_COMMENT: begin
        if (b == C_NL) begin
          add_token(K_COMMENT, tok_start, off - tok_start, 32'd0, 8'd0);
          lx_mode = M_IDLE;
        end else if (b == C_NUL) begin
          add_token(K_COMMENT, tok_start, off - tok_start, 32'd0, 8'd0);
          end_of_text(off);
        end
      end
      M_AMP:   finish_op(b, off, C_AMP, K_AMPAMP, 8'd0, K_IDENT, K_AMP);
      M_BAR:   finish_op(b, off, C_BAR, K_BARBAR, 8'd0, K_IDENT, K_BAR);
      M_PLUS:  finish_op(b, off, C_PLUS, K_INC, C_EQ, K_PLUSEQ, K_PLUS);
      M_MINUS: finish_op(b, off, C_MINUS, K_DEC, C_EQ, K_MINUSEQ, K_MINUS);
      M_EQ:    finish_op(b, off, C_EQ, K_EQEQ, 8'd0, K_IDENT, K_ASSIGN);
      M_SKIP:  if (b == C_NUL) end_of_text(off);
      default: begin_token(b, off);
    endcase
    cur_off = (b == C_NUL) ? 16'd0 : off + 16'd1;
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) token_q.push_back(step_q[i]);
  endtask

  // ---------------- stimulus builders ----------------
  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(int'(s[i]));
  endtask

  function automatic int word_byte();
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$0123456789";
    return int'(pool[$urandom_range(pool.len() - 1)]);
  endfunction

  // One text of random tokens, mostly well formed, closed by byte 0
  task automatic put_random_text();
    string ops[19] = '{"(", ")", "[", "]", "{", "}", ",", "&", "&&", "|", "||",
                       "+", "++", "+=", "-", "--", "-=", "=", "=="};
    string esc = "\\\"n0q";
    int    ntok;
    int    len;
    int    b;
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(9))
        0: begin
          if ($urandom_range(3) == 0) put_str(kw_names[$urandom_range(7)]);
          else begin
            text_q.push_back(int'("x") + $urandom_range(1) * 2);
            len = $urandom_range(0, 10);
            repeat (len) text_q.push_back(word_byte());
          end
        end
        1: begin
          len = ($urandom_range(7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
          repeat (len) text_q.push_back(int'("0") + $urandom_range(9));
        end
        2: begin
          text_q.push_back(C_QUOTE);
          len = $urandom_range(0, 5);
          repeat (len) begin
            if ($urandom_range(3) == 0) begin
              text_q.push_back(C_BSLASH);
              text_q.push_back(int'(esc[$urandom_range(4)]));
            end else begin
              do b = $urandom_range(1, 255); while (b == C_QUOTE || b == C_BSLASH);
              text_q.push_back(b);
            end
          end
          text_q.push_back(C_QUOTE);
        end
        3: begin
          text_q.push_back(C_HASH);
          len = $urandom_range(0, 6);
          repeat (len) begin
            do b = $urandom_range(1, 255); while (b == C_NL);
            text_q.push_back(b);
          end
          if ($urandom_range(3) != 0) text_q.push_back(C_NL);
        end
        4, 5, 6: put_str(ops[$urandom_range(18)]);
        7: text_q.push_back($urandom_range(2) == 0 ? C_TAB : $urandom_range(1) ? C_NL : C_SPACE);
        8: text_q.push_back($urandom_range(0, 255));
        default: begin
          if ($urandom_range(1)) text_q.push_back(int'("@"));
          else put_str($urandom_range(1) ? "\"ab" : "\"a\\");
        end
      endcase
      if ($urandom_range(2) == 0) text_q.push_back(C_SPACE);
    end
    text_q.push_back(C_NUL);
  endtask

  // ---------------- driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      text_byte <= 8'h00;
    end else begin : drive
      logic       nxt_push;
      logic [7:0] nxt_byte;
      bit         blocked;
      nxt_push = push;
      nxt_byte = text_byte;
      blocked = 0;
      if (push && !full) begin
        lex_byte(text_byte);
        nxt_push = 1'b0;
      end
      if (!(push && full)) begin
        while (!blocked && text_q.size() > 0 && text_q[0] < 0) begin
          case (text_q[0])
            DRAIN:   blocked = (token_q.size() != 0);
            HOLD:    hold_req++;
            PHASE_A: begin snd_idle = 30; rcv_idle = 64; end
            PHASE_B: begin snd_idle = 64; rcv_idle = 30; end
            default: begin snd_idle = 0; rcv_idle = 0; end
          endcase
          if (!blocked) void'(text_q.pop_front());
        end
        if (!blocked && text_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
          nxt_push = 1'b1;
          nxt_byte = 8'(text_q.pop_front());
        end
      end
      push <= nxt_push;
      text_byte <= nxt_byte;
    end
  end

  // ---------------- monitor ----------------
  int hold_cnt = 0;
  int hold_seen = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin : watch
      token_t e;
      if (pop && !empty) begin
        if (token_q.size() == 0) begin
          report($sformatf("unexpected record kind %0d", token_kind));
        end else begin
          e = token_q.pop_front();
          if (token_kind !== e.kind)
            report($sformatf("kind %0d, want %0d", token_kind, e.kind));
          if (token_start !== e.start)
            report($sformatf("start %0d, want %0d", token_start, e.start));
          if (token_length !== e.length)
            report($sformatf("length %0d, want %0d", token_length, e.length));
          if (integer_value !== e.value)
            report($sformatf("value %0d, want %0d", integer_value, e.value));
          if (string_char !== e.ch)
            report($sformatf("char %0h, want %0h", string_char, e.ch));
          if (last_of_run !== e.last)
            report($sformatf("last %0b, want %0b", last_of_run, e.last));
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Stall watchdog: no transaction on either side for too long
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    // Directed texts: keywords, operators, escapes, saturation, errors
    put_str("if else for while return break continue function");
    text_q.push_back(C_NUL);
    put_str("iff _$9 functions 4294967296 7(");
    text_q.push_back(C_NUL);
    put_str("\"a\\n\\q\\\"\\\\\\0\" #c\n()[]{},&&&|||++++=---=====+-=@x");
    text_q.push_back(C_NUL);
    put_str("\"ab\\");
    text_q.push_back(C_NUL);
    put_str("#open");
    text_q.push_back(C_NUL);
    text_q.push_back(DRAIN);
    text_q.push_back(PHASE_A);
    for (int i = 0; i < 30; i++) put_random_text();
    text_q.push_back(HOLD);
    for (int i = 0; i < 5; i++) put_random_text();
    text_q.push_back(DRAIN);
    text_q.push_back(PHASE_B);
    for (int i = 0; i < 30; i++) put_random_text();
    text_q.push_back(PHASE_C);
    for (int i = 0; i < 30; i++) put_random_text();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (text_q.size() > 0 || push || token_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && token_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
